### src/pip_pkg.sv
// Shared types, constants and codes for the point-in-polygon mask block.
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 24;
    localparam int TAG_BITS     = 32;
    localparam int IDX_BITS     = $clog2(MAX_VERTICES);
    localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
    localparam int ISSUE_BITS   = $clog2(MAX_VERTICES + 2);
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * DIFF_BITS;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_INFLIGHT = QUEUE_DEPTH + 2;
    localparam int PEND_BITS    = $clog2(MAX_INFLIGHT + 1);

    localparam logic [1:0] FUNC_APPEND = 2'd0;
    localparam logic [1:0] FUNC_TEST   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [1:0] FUNC_NOP    = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_TEST,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef enum logic {
        BK_IDLE,
        BK_WALK
    } back_state_t;

    typedef struct packed {
        logic [1:0]                   func;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic [TAG_BITS-1:0]          point_tag;
    } in_t;

    typedef struct packed {
        logic                inside_res;
        logic [TAG_BITS-1:0] tag_out;
        logic [1:0]          status;
    } out_t;

    typedef struct packed {
        op_t                          op;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic [TAG_BITS-1:0]          tag;
    } q_item_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_stat_t;

endpackage

### src/pip_front.sv
// Front end: accepts transactions, decodes the function code, feeds the queue.
module pip_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pip_pkg::in_t      item,
    input  pip_pkg::q_stat_t  q_stat,
    output logic              push,
    output pip_pkg::q_item_t  push_item
);

    logic             vld_reg;
    logic             vld_next;
    pip_pkg::q_item_t item_reg;
    pip_pkg::q_item_t item_next;
    logic             accept;

    assign busy      = vld_reg && q_stat.full;
    assign accept    = start && !busy;
    assign push      = vld_reg && !q_stat.full;
    assign push_item = item_reg;

    always_comb
    begin
        item_next.coord_x = item.coord_x;
        item_next.coord_y = item.coord_y;
        item_next.tag     = item.point_tag;
        case (item.func)
            pip_pkg::FUNC_APPEND: item_next.op = pip_pkg::OP_APPEND;
            pip_pkg::FUNC_TEST:   item_next.op = pip_pkg::OP_TEST;
            pip_pkg::FUNC_CLEAR:  item_next.op = pip_pkg::OP_CLEAR;
            default:              item_next.op = pip_pkg::OP_NOP;
        endcase
        if (accept)
        begin
            vld_next = 1'b1;
        end
        else if (push)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

### src/pip_queue.sv
// Short FIFO of decoded transactions between front and back.
module pip_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pip_pkg::q_item_t  push_item,
    input  logic              pop,
    output pip_pkg::q_item_t  head,
    output pip_pkg::q_stat_t  q_stat
);

    pip_pkg::q_item_t                  entry_reg [pip_pkg::QUEUE_DEPTH];
    logic [pip_pkg::QPTR_BITS-1:0]     wr_ptr_reg;
    logic [pip_pkg::QPTR_BITS-1:0]     wr_ptr_next;
    logic [pip_pkg::QPTR_BITS-1:0]     rd_ptr_reg;
    logic [pip_pkg::QPTR_BITS-1:0]     rd_ptr_next;
    logic [pip_pkg::QCNT_BITS-1:0]     cnt_reg;
    logic [pip_pkg::QCNT_BITS-1:0]     cnt_next;
    logic                              do_push;
    logic                              do_pop;

    assign q_stat.full      = (cnt_reg == pip_pkg::QCNT_BITS'(pip_pkg::QUEUE_DEPTH));
    assign q_stat.not_empty = (cnt_reg != '0);
    assign head             = entry_reg[rd_ptr_reg];
    assign do_push          = push && !q_stat.full;
    assign do_pop           = pop && q_stat.not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == pip_pkg::QPTR_BITS'(pip_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == pip_pkg::QPTR_BITS'(pip_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### src/pip_back.sv
// Back end: vertex table, edge walk with crossing test, result register.
module pip_back (
    input  logic              clk,
    input  logic              rst_n,
    input  pip_pkg::q_stat_t  q_stat,
    input  pip_pkg::q_item_t  head,
    output logic              pop,
    output pip_pkg::out_t     result,
    output logic              result_strobe
);

    logic signed [pip_pkg::COORD_BITS-1:0] mem_x [pip_pkg::MAX_VERTICES];
    logic signed [pip_pkg::COORD_BITS-1:0] mem_y [pip_pkg::MAX_VERTICES];

    pip_pkg::back_state_t             state_reg;
    pip_pkg::back_state_t             state_next;
    logic [pip_pkg::CNT_BITS-1:0]     count_reg;
    logic [pip_pkg::CNT_BITS-1:0]     count_next;
    logic [pip_pkg::ISSUE_BITS-1:0]   issue_reg;
    logic [pip_pkg::ISSUE_BITS-1:0]   issue_next;
    logic                             inside_reg;
    logic                             inside_next;
    logic                             rd_vld_reg;
    logic                             rd_vld_next;
    logic                             rd_first_reg;
    logic                             rd_first_next;
    logic                             s1_vld_reg;
    logic                             s2_vld_reg;
    logic                             strobe_reg;
    logic                             strobe_next;
    pip_pkg::out_t                    res_reg;
    pip_pkg::out_t                    res_next;

    logic signed [pip_pkg::COORD_BITS-1:0] px_reg;
    logic signed [pip_pkg::COORD_BITS-1:0] py_reg;
    logic [pip_pkg::TAG_BITS-1:0]          tag_reg;
    logic                                  load_pt;

    logic                             wr_en;
    logic [pip_pkg::IDX_BITS-1:0]     wr_idx;
    logic [pip_pkg::IDX_BITS-1:0]     rd_idx;
    logic signed [pip_pkg::COORD_BITS-1:0] rd_x_reg;
    logic signed [pip_pkg::COORD_BITS-1:0] rd_y_reg;
    logic signed [pip_pkg::COORD_BITS-1:0] old_x_reg;
    logic signed [pip_pkg::COORD_BITS-1:0] old_y_reg;

    logic signed [pip_pkg::DIFF_BITS-1:0]  x1;
    logic signed [pip_pkg::DIFF_BITS-1:0]  x2;
    logic signed [pip_pkg::DIFF_BITS-1:0]  y1;
    logic signed [pip_pkg::DIFF_BITS-1:0]  y2;
    logic signed [pip_pkg::DIFF_BITS-1:0]  pxe;
    logic signed [pip_pkg::DIFF_BITS-1:0]  pye;
    logic                                  span_hit;
    logic signed [pip_pkg::DIFF_BITS-1:0]  da_reg;
    logic signed [pip_pkg::DIFF_BITS-1:0]  db_reg;
    logic signed [pip_pkg::DIFF_BITS-1:0]  dc_reg;
    logic signed [pip_pkg::DIFF_BITS-1:0]  dd_reg;
    logic                                  cross1_reg;
    logic signed [pip_pkg::PROD_BITS-1:0]  p1_reg;
    logic signed [pip_pkg::PROD_BITS-1:0]  p2_reg;
    logic                                  cross2_reg;
    logic                                  edge_vld;
    logic                                  issue_done;

    assign result        = res_reg;
    assign result_strobe = strobe_reg;
    assign wr_idx        = count_reg[pip_pkg::IDX_BITS-1:0];
    assign issue_done    = (issue_reg > pip_pkg::ISSUE_BITS'(count_reg));
    assign edge_vld      = rd_vld_reg && !rd_first_reg;

    // Edge from the previous vertex to the one just read.
    always_comb
    begin
        pxe      = pip_pkg::DIFF_BITS'(px_reg);
        pye      = pip_pkg::DIFF_BITS'(py_reg);
        span_hit = ((rd_x_reg < px_reg) == (px_reg <= old_x_reg));
        if (rd_x_reg > old_x_reg)
        begin
            x1 = pip_pkg::DIFF_BITS'(old_x_reg);
            y1 = pip_pkg::DIFF_BITS'(old_y_reg);
            x2 = pip_pkg::DIFF_BITS'(rd_x_reg);
            y2 = pip_pkg::DIFF_BITS'(rd_y_reg);
        end
        else
        begin
            x1 = pip_pkg::DIFF_BITS'(rd_x_reg);
            y1 = pip_pkg::DIFF_BITS'(rd_y_reg);
            x2 = pip_pkg::DIFF_BITS'(old_x_reg);
            y2 = pip_pkg::DIFF_BITS'(old_y_reg);
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        issue_next         = issue_reg;
        inside_next        = inside_reg;
        rd_vld_next        = 1'b0;
        rd_first_next      = 1'b0;
        strobe_next        = 1'b0;
        res_next           = res_reg;
        pop                = 1'b0;
        wr_en              = 1'b0;
        load_pt            = 1'b0;
        rd_idx             = (issue_reg == '0) ? pip_pkg::IDX_BITS'(count_reg - 1'b1)
                                               : pip_pkg::IDX_BITS'(issue_reg - 1'b1);
        if (s2_vld_reg && cross2_reg && (p1_reg < p2_reg))
        begin
            inside_next = !inside_reg;
        end
        case (state_reg)
            pip_pkg::BK_IDLE:
            begin
                if (q_stat.not_empty)
                begin
                    pop                = 1'b1;
                    res_next.inside_res = 1'b0;
                    res_next.tag_out   = head.tag;
                    res_next.status    = pip_pkg::STATUS_OK;
                    case (head.op)
                        pip_pkg::OP_APPEND:
                        begin
                            strobe_next = 1'b1;
                            if (count_reg < pip_pkg::CNT_BITS'(pip_pkg::MAX_VERTICES))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                res_next.status = pip_pkg::STATUS_FULL;
                            end
                        end
                        pip_pkg::OP_CLEAR:
                        begin
                            strobe_next = 1'b1;
                            count_next  = '0;
                        end
                        pip_pkg::OP_TEST:
                        begin
                            if (count_reg == '0)
                            begin
                                strobe_next     = 1'b1;
                                res_next.status = pip_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                load_pt     = 1'b1;
                                issue_next  = '0;
                                inside_next = 1'b0;
                                state_next  = pip_pkg::BK_WALK;
                            end
                        end
                        default:
                        begin
                            strobe_next = 1'b1;
                        end
                    endcase
                end
            end
            pip_pkg::BK_WALK:
            begin
                if (!issue_done)
                begin
                    rd_vld_next   = 1'b1;
                    rd_first_next = (issue_reg == '0);
                    issue_next    = issue_reg + 1'b1;
                end
                else if (!rd_vld_reg && !s1_vld_reg && !s2_vld_reg)
                begin
                    strobe_next         = 1'b1;
                    res_next.inside_res = inside_reg;
                    res_next.tag_out    = tag_reg;
                    res_next.status     = pip_pkg::STATUS_OK;
                    state_next          = pip_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = pip_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pip_pkg::BK_IDLE;
            count_reg    <= '0;
            issue_reg    <= '0;
            inside_reg   <= 1'b0;
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            inside_reg   <= inside_next;
            rd_vld_reg   <= rd_vld_next;
            rd_first_reg <= rd_first_next;
            s1_vld_reg   <= edge_vld;
            s2_vld_reg   <= s1_vld_reg;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_idx] <= head.coord_x;
            mem_y[wr_idx] <= head.coord_y;
        end
        rd_x_reg <= mem_x[rd_idx];
        rd_y_reg <= mem_y[rd_idx];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (load_pt)
        begin
            px_reg  <= head.coord_x;
            py_reg  <= head.coord_y;
            tag_reg <= head.tag;
        end
        if (rd_vld_reg)
        begin
            old_x_reg <= rd_x_reg;
            old_y_reg <= rd_y_reg;
        end
        da_reg     <= pye - y1;
        db_reg     <= x2 - x1;
        dc_reg     <= y2 - y1;
        dd_reg     <= pxe - x1;
        cross1_reg <= span_hit;
        p1_reg     <= pip_pkg::PROD_BITS'(da_reg) * pip_pkg::PROD_BITS'(db_reg);
        p2_reg     <= pip_pkg::PROD_BITS'(dc_reg) * pip_pkg::PROD_BITS'(dd_reg);
        cross2_reg <= cross1_reg;
    end

endmodule

### src/point_in_polygon_mask.sv
// Top level of the even-odd point-in-polygon mask block.
//
//  channel   ports                          transfer
//  -------   -----------------------------  ----------------------------
//  input     start, busy, item              start && !busy at clk rise
//  result    result_strobe, result          one cycle per transaction
//
// Append, clear and unused codes, and a test on an empty table, are done in the
// back end's idle state; any other test holds it in the walk state while the
// stored vertices pass the single read port of the vertex table (one vertex per
// cycle) and the three-stage crossing pipe. On an idle block an accepted item
// passes the front register and the queue; the back end registers its strobe.
// Reset clears the vertex count, queue and handshake state, not the table. busy
// rises when the front register and queue are full; results are never held off.
module point_in_polygon_mask (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  pip_pkg::in_t   item,
    output logic           result_strobe,
    output pip_pkg::out_t  result
);

    pip_pkg::q_stat_t  q_stat;
    pip_pkg::q_item_t  push_item;
    pip_pkg::q_item_t  head;
    logic              push;
    logic              pop;

    pip_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    pip_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    pip_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .head          (head),
        .pop           (pop),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

### src/pip_checker.sv
// Port-level checks for the point-in-polygon mask block, bound to the top.
module pip_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  logic           result_strobe,
    input  pip_pkg::out_t  result
);

    logic [pip_pkg::PEND_BITS-1:0] pending_reg;
    logic [pip_pkg::PEND_BITS-1:0] pending_next;
    logic                          accept;

    assign accept = start && !busy;

    always_comb
    begin
        pending_next = pending_reg;
        if (accept && !result_strobe)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (result_strobe && !accept)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> pending_reg != '0)
        else $error("result without an outstanding transaction");

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= pip_pkg::PEND_BITS'(pip_pkg::MAX_INFLIGHT))
        else $error("more transactions in flight than the block can hold");

    a_busy_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> pending_reg != '0)
        else $error("busy with nothing outstanding");

    a_flag_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.status != pip_pkg::STATUS_OK) |-> !result.inside_res)
        else $error("inside flag set on a non-ok result");

    a_clean_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> (!busy && !result_strobe))
        else $error("handshake not idle after reset");

endmodule

bind point_in_polygon_mask pip_checker u_pip_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_strobe (result_strobe),
    .result        (result)
);

### dv/tb.sv
// Testbench for point_in_polygon_mask: predicts every transaction and checks each result.
`timescale 1ns / 1ps

module tb;

    localparam int ITEM_TARGET = 1750;
    localparam int QUIET_AFTER = 1550;
    localparam int C_MAX       = (1 << (pip_pkg::COORD_BITS - 1)) - 1;
    localparam int C_MIN       = -(1 << (pip_pkg::COORD_BITS - 1));
    localparam int SC_NEAR     = 0;
    localparam int SC_MID      = 1;
    localparam int SC_FULL     = 2;

    class pip_scoreboard;
        longint               vert_x[pip_pkg::MAX_VERTICES];
        longint               vert_y[pip_pkg::MAX_VERTICES];
        int unsigned          vert_count;
        pip_pkg::out_t        expected_results[$];
        int                   mismatches;

        function bit crossing_parity(longint px, longint py);
            bit     inside_flag;
            longint xo, yo, xn, yn, x1, x2, y1, y2;
            inside_flag = 1'b0;
            xo = vert_x[vert_count - 1];
            yo = vert_y[vert_count - 1];
            for (int i = 0; i < vert_count; i++)
            begin
                xn = vert_x[i];
                yn = vert_y[i];
                if (xn > xo)
                begin
                    x1 = xo; x2 = xn; y1 = yo; y2 = yn;
                end
                else
                begin
                    x1 = xn; x2 = xo; y1 = yn; y2 = yo;
                end
                if (((xn < px) == (px <= xo)) &&
                    ((py - y1) * (x2 - x1) < (y2 - y1) * (px - x1)))
                    inside_flag = !inside_flag;
                xo = xn;
                yo = yn;
            end
            return inside_flag;
        endfunction

        function void predict_item(pip_pkg::in_t it);
            pip_pkg::out_t r;
            r.inside_res = 1'b0;
            r.tag_out    = it.point_tag;
            r.status     = pip_pkg::STATUS_OK;
            case (it.func)
                pip_pkg::FUNC_APPEND:
                begin
                    if (vert_count < pip_pkg::MAX_VERTICES)
                    begin
                        vert_x[vert_count] = longint'($signed(it.coord_x));
                        vert_y[vert_count] = longint'($signed(it.coord_y));
                        vert_count++;
                    end
                    else
                        r.status = pip_pkg::STATUS_FULL;
                end
                pip_pkg::FUNC_TEST:
                begin
                    if (vert_count == 0)
                        r.status = pip_pkg::STATUS_EMPTY;
                    else
                        r.inside_res = crossing_parity(longint'($signed(it.coord_x)),
                                                       longint'($signed(it.coord_y)));
                end
                pip_pkg::FUNC_CLEAR:
                    vert_count = 0;
                default: ;
            endcase
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void compare_result(pip_pkg::out_t got);
            pip_pkg::out_t want;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: tag_out %h", got.tag_out);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (got.inside_res !== want.inside_res)
            begin
                $error("inside_res: expected %0d, actual %0d", want.inside_res, got.inside_res);
                mismatches++;
            end
            if (got.tag_out !== want.tag_out)
            begin
                $error("tag_out: expected %h, actual %h", want.tag_out, got.tag_out);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    pip_pkg::in_t  item;
    logic          result_strobe;
    pip_pkg::out_t result;

    pip_scoreboard sb;
    int            sent;

    point_in_polygon_mask i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result_strobe (result_strobe),
        .result        (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.predict_item(item);
        if (rst_n && result_strobe)
            sb.compare_result(result);
    end

    function automatic int rand_coord(int scale);
        case (scale)
            SC_NEAR: return int'($urandom_range(0, 4000)) - 2000;
            SC_MID:  return int'($urandom_range(0, 131072)) - 65536;
            default: return int'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [1:0] f, input int x, input int y);
        pip_pkg::in_t it;
        it.func      = f;
        it.coord_x   = pip_pkg::COORD_BITS'(x);
        it.coord_y   = pip_pkg::COORD_BITS'(y);
        it.point_tag = $urandom;
        if (sent < QUIET_AFTER && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge clk);
        end
        @(negedge clk);
        start = 1'b1;
        item  = it;
        do @(posedge clk); while (busy);
        sent++;
    endtask

    task automatic run_directed();
        send_item(pip_pkg::FUNC_TEST, 0, 0);
        send_item(pip_pkg::FUNC_NOP, C_MAX, C_MIN);
        send_item(pip_pkg::FUNC_APPEND, 0, 0);
        send_item(pip_pkg::FUNC_TEST, 0, 0);
        send_item(pip_pkg::FUNC_APPEND, C_MAX, C_MIN);
        send_item(pip_pkg::FUNC_TEST, 10, -10);
        send_item(pip_pkg::FUNC_CLEAR, 0, 0);
        send_item(pip_pkg::FUNC_APPEND, -1000, -1000);
        send_item(pip_pkg::FUNC_APPEND, 1000, -1000);
        send_item(pip_pkg::FUNC_APPEND, 1000, 1000);
        send_item(pip_pkg::FUNC_APPEND, -1000, 1000);
        send_item(pip_pkg::FUNC_TEST, 0, 0);
        send_item(pip_pkg::FUNC_TEST, 2000, 0);
        send_item(pip_pkg::FUNC_TEST, 1000, 0);
        send_item(pip_pkg::FUNC_TEST, -1000, 0);
        send_item(pip_pkg::FUNC_TEST, -1000, -1000);
        send_item(pip_pkg::FUNC_TEST, 1000, 1000);
        send_item(pip_pkg::FUNC_TEST, 0, 1000);
        send_item(pip_pkg::FUNC_TEST, C_MIN, C_MIN);
        send_item(pip_pkg::FUNC_CLEAR, 0, 0);
        send_item(pip_pkg::FUNC_APPEND, C_MIN, C_MIN);
        send_item(pip_pkg::FUNC_APPEND, C_MAX, C_MIN);
        send_item(pip_pkg::FUNC_APPEND, 0, C_MAX);
        send_item(pip_pkg::FUNC_TEST, 0, 0);
        send_item(pip_pkg::FUNC_TEST, C_MAX, C_MAX);
    endtask

    task automatic run_random();
        int px[80];
        int py[80];
        int tx, ty;
        int scale, nv, nt, pick;
        while (sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                send_item(2'($urandom_range(0, 3)), rand_coord(SC_FULL), rand_coord(SC_FULL));
                continue;
            end
            pick  = int'($urandom_range(0, 9));
            scale = (pick < 5) ? SC_NEAR : (pick < 8) ? SC_MID : SC_FULL;
            if ($urandom_range(0, 9) != 0)
                send_item(pip_pkg::FUNC_CLEAR, rand_coord(SC_FULL), rand_coord(SC_FULL));
            nv = ($urandom_range(0, 19) == 0) ? int'($urandom_range(60, 68))
                                               : int'($urandom_range(1, 12));
            for (int i = 0; i < nv; i++)
            begin
                px[i] = rand_coord(scale);
                py[i] = rand_coord(scale);
                send_item(pip_pkg::FUNC_APPEND, px[i], py[i]);
            end
            nt = int'($urandom_range(2, 16));
            for (int i = 0; i < nt; i++)
            begin
                pick = int'($urandom_range(0, 5));
                tx   = rand_coord(scale);
                ty   = rand_coord(scale);
                if (pick == 0)
                begin
                    tx = px[$urandom_range(0, nv - 1)];
                    ty = py[$urandom_range(0, nv - 1)];
                end
                else if (pick == 1)
                    tx = px[$urandom_range(0, nv - 1)];
                else if (pick == 2)
                    ty = py[$urandom_range(0, nv - 1)];
                send_item(pip_pkg::FUNC_TEST, tx, ty);
            end
        end
    endtask

    initial
    begin
        sb    = new();
        sent  = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        run_random();
        @(negedge clk);
        start = 1'b0;

        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
src/pip_pkg.sv
src/pip_front.sv
src/pip_queue.sv
src/pip_back.sv
src/point_in_polygon_mask.sv
src/pip_checker.sv
dv/tb.sv
